// ===== rtl/core/hrfp_pkg.sv =====
// Package for the H.265 RTP fragmentation-unit packetizer.
// Holds field widths, protocol constants and the command type passed
// from the front part to the back part. No dependencies.
package hrfp_pkg;

    localparam int MAX_UNIT_BYTES_DEF = 1048576;

    localparam int BYTE_W   = 8;
    localparam int LEN_IN_W = 21;
    localparam int MP_W     = 11;
    localparam int TYPE_W   = 6;

    localparam logic [MP_W-1:0] MP_MIN       = 11'd16;
    localparam logic [MP_W-1:0] MP_MAX       = 11'd1500;
    localparam logic [MP_W-1:0] MP_RESET     = 11'd1400;
    localparam logic [MP_W-1:0] FU_HDR_BYTES = 11'd3;

    localparam int NAL_HDR_BYTES = 2;

    localparam logic [BYTE_W-1:0] FU_TYPE_BYTE = 8'(49 << 1);
    localparam logic [BYTE_W-1:0] FLAG_S       = 8'(1 << 7);
    localparam logic [BYTE_W-1:0] FLAG_E       = 8'(1 << 6);

    localparam int QDEPTH = 4;

    // One queued command: an optional three-byte fragment header, then one data beat.
    typedef struct packed {
        logic              hdr;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] hdr2;
        logic [BYTE_W-1:0] hdr3;
        logic              ps;
        logic              pe;
        logic              mk;
        logic              ks;
    } cmd_t;

endpackage

// ===== rtl/core/hrfp_front.sv =====
// Front part of the packetizer: holds the payload-size register, tracks the
// position within the NAL unit and classifies each byte into a command.
// Depends on hrfp_pkg.
module hrfp_front #(
    parameter int MAX_UNIT_BYTES = hrfp_pkg::MAX_UNIT_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [hrfp_pkg::MP_W-1:0]      cfg_data,
    input  logic                           push,
    input  logic [hrfp_pkg::BYTE_W-1:0]    nal_byte,
    input  logic [hrfp_pkg::LEN_IN_W-1:0]  nal_length,
    input  logic                           key_unit,
    input  logic                           first_byte,
    input  logic                           q_full,
    output logic                           cmd_push,
    output hrfp_pkg::cmd_t                 cmd
);

    localparam int POS_W = $clog2(MAX_UNIT_BYTES);
    localparam int LEN_W = $clog2(MAX_UNIT_BYTES + 1);
    localparam int WW    = (LEN_W > hrfp_pkg::LEN_IN_W) ? LEN_W : hrfp_pkg::LEN_IN_W;
    localparam logic [WW-1:0] LEN_MAX = WW'(MAX_UNIT_BYTES);
    localparam int MP_W  = hrfp_pkg::MP_W;

    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [MP_W-1:0]             fl_reg, fl_next;
    logic                        fragmenting_reg, fragmenting_next;
    logic [hrfp_pkg::TYPE_W-1:0] unit_type_reg, unit_type_next;
    logic [hrfp_pkg::BYTE_W-1:0] second_header_reg, second_header_next;
    logic                        ff_reg, ff_next;
    logic [MP_W-1:0]             mp_reg, mp_next;
    logic [MP_W-1:0]             chunk_reg, chunk_next;

    logic            accept;
    logic [MP_W-1:0] cfg_clamped;
    logic [WW-1:0]   len_ext, len, pos_raw, pos, pos_inc, rem;
    logic            start, frag, last, pos_ge2, pos_is1;
    logic            need_hdr, hdr_fin, fin_cont, fin, frag_end, ff;
    logic [MP_W-1:0] fl0, fl_set, fl_dec;
    logic [hrfp_pkg::BYTE_W-1:0] flags;

    assign accept = push && !q_full;

    always_comb
    begin
        if (cfg_data < hrfp_pkg::MP_MIN)
            cfg_clamped = hrfp_pkg::MP_MIN;
        else if (cfg_data > hrfp_pkg::MP_MAX)
            cfg_clamped = hrfp_pkg::MP_MAX;
        else
            cfg_clamped = cfg_data;
    end

    always_comb
    begin
        len_ext = WW'(nal_length);
        if (len_ext == '0)
            len = WW'(1);
        else if (len_ext > LEN_MAX)
            len = LEN_MAX;
        else
            len = len_ext;

        pos_raw = first_byte ? '0 : WW'(pos_reg);
        pos     = (pos_raw >= len) ? '0 : pos_raw;
        start   = (pos == '0);
        pos_inc = pos + WW'(1);
        last    = (pos_inc >= len);
        rem     = len - pos;
        pos_ge2 = (pos >= WW'(hrfp_pkg::NAL_HDR_BYTES));
        pos_is1 = (pos == WW'(hrfp_pkg::NAL_HDR_BYTES - 1));

        // Fragment mode is chosen on the first byte: length above max_payload - 1.
        frag = start ? (len >= WW'(mp_reg)) : fragmenting_reg;
        fl0  = start ? '0 : fl_reg;
        ff   = start ? 1'b1 : ff_reg;

        need_hdr = frag && pos_ge2 && (fl0 == '0);
        hdr_fin  = (rem <= WW'(chunk_reg));
        fin_cont = (rem <= WW'(fl0));
        fin      = need_hdr ? hdr_fin : fin_cont;
        if (need_hdr)
            fl_set = hdr_fin ? rem[MP_W-1:0] : chunk_reg;
        else
            fl_set = fl0;
        fl_dec   = fl_set - MP_W'(1);
        frag_end = (fl_dec == '0) || last;

        if (hdr_fin)
            flags = hrfp_pkg::FLAG_E;
        else
            flags = ff ? hrfp_pkg::FLAG_S : '0;

        cmd.hdr  = need_hdr;
        cmd.data = nal_byte;
        cmd.hdr2 = second_header_reg;
        cmd.hdr3 = flags | {2'b00, unit_type_reg};
        cmd.ps   = !frag && start;
        cmd.pe   = frag ? frag_end : last;
        cmd.mk   = frag && fin;
        cmd.ks   = frag ? (ff && key_unit) : key_unit;
        cmd_push = accept && (!frag || pos_ge2);

        pos_next           = pos_reg;
        fl_next            = fl_reg;
        fragmenting_next   = fragmenting_reg;
        unit_type_next     = unit_type_reg;
        second_header_next = second_header_reg;
        ff_next            = ff_reg;
        if (accept)
        begin
            pos_next         = last ? '0 : pos_inc[POS_W-1:0];
            fragmenting_next = frag;
            if (frag && pos_ge2)
            begin
                fl_next = frag_end ? '0 : fl_dec;
                ff_next = frag_end ? 1'b0 : ff;
            end
            else
            begin
                fl_next = fl0;
                ff_next = ff;
            end
            if (frag && start)
                unit_type_next = nal_byte[hrfp_pkg::TYPE_W:1];
            if (frag && pos_is1)
                second_header_next = nal_byte;
        end

        mp_next    = cfg_write ? cfg_clamped : mp_reg;
        chunk_next = cfg_write ? (cfg_clamped - hrfp_pkg::FU_HDR_BYTES) : chunk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            fl_reg            <= '0;
            fragmenting_reg   <= 1'b0;
            unit_type_reg     <= '0;
            second_header_reg <= '0;
            ff_reg            <= 1'b1;
            mp_reg            <= hrfp_pkg::MP_RESET;
            chunk_reg         <= hrfp_pkg::MP_RESET - hrfp_pkg::FU_HDR_BYTES;
        end
        else
        begin
            pos_reg           <= pos_next;
            fl_reg            <= fl_next;
            fragmenting_reg   <= fragmenting_next;
            unit_type_reg     <= unit_type_next;
            second_header_reg <= second_header_next;
            ff_reg            <= ff_next;
            mp_reg            <= mp_next;
            chunk_reg         <= chunk_next;
        end
    end

endmodule

// ===== rtl/core/hrfp_cmd_fifo.sv =====
// Short command queue between the front and back parts of the packetizer.
// Depends on hrfp_pkg.
module hrfp_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  hrfp_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output hrfp_pkg::cmd_t rd_data,
    output logic           rd_valid
);

    localparam int QW = $clog2(hrfp_pkg::QDEPTH);

    hrfp_pkg::cmd_t entry_reg [hrfp_pkg::QDEPTH];
    logic [QW-1:0]  wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [QW:0]    count_reg, count_next;
    logic           do_wr, do_rd;

    assign full     = (count_reg == (QW+1)'(hrfp_pkg::QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + QW'(1) : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + QW'(1) : rptr_reg;
        count_next = count_reg + (QW+1)'(do_wr) - (QW+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/hrfp_back.sv =====
// Back part of the packetizer: expands each command into beats, inserting the
// three fragment header bytes where asked, into a registered output stage.
// Depends on hrfp_pkg.
module hrfp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hrfp_pkg::cmd_t              head,
    input  logic                        head_valid,
    output logic                        head_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [hrfp_pkg::BYTE_W-1:0] out_byte,
    output logic                        packet_start,
    output logic                        packet_end,
    output logic                        marker,
    output logic                        key_start
);

    typedef enum logic [1:0] {
        STEP_PT,
        STEP_NUH,
        STEP_FU,
        STEP_DATA
    } step_t;

    step_t                       step_reg, step_next;
    logic                        valid_reg, valid_next;
    logic [hrfp_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                        ps_reg, ps_next, pe_reg, pe_next;
    logic                        mk_reg, mk_next, ks_reg, ks_next;
    logic                        load, hdr_beat;

    assign load     = !valid_reg || pop;
    assign hdr_beat = head.hdr && (step_reg != STEP_DATA);
    assign head_pop = load && head_valid && !hdr_beat;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        ps_next    = ps_reg;
        pe_next    = pe_reg;
        mk_next    = mk_reg;
        ks_next    = ks_reg;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                mk_next = head.mk;
                ks_next = head.ks;
                if (hdr_beat)
                begin
                    case (step_reg)
                        STEP_PT:
                        begin
                            byte_next = hrfp_pkg::FU_TYPE_BYTE;
                            step_next = STEP_NUH;
                        end
                        STEP_NUH:
                        begin
                            byte_next = head.hdr2;
                            step_next = STEP_FU;
                        end
                        STEP_FU:
                        begin
                            byte_next = head.hdr3;
                            step_next = STEP_DATA;
                        end
                        default:
                        begin
                            byte_next = head.data;
                            step_next = STEP_PT;
                        end
                    endcase
                    ps_next = (step_reg == STEP_PT);
                    pe_next = 1'b0;
                end
                else
                begin
                    byte_next = head.data;
                    ps_next   = head.ps;
                    pe_next   = head.pe;
                    step_next = STEP_PT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_PT;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            ps_reg    <= 1'b0;
            pe_reg    <= 1'b0;
            mk_reg    <= 1'b0;
            ks_reg    <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
            byte_reg  <= byte_next;
            ps_reg    <= ps_next;
            pe_reg    <= pe_next;
            mk_reg    <= mk_next;
            ks_reg    <= ks_next;
        end
    end

    assign empty        = !valid_reg;
    assign out_byte     = byte_reg;
    assign packet_start = ps_reg;
    assign packet_end   = pe_reg;
    assign marker       = mk_reg;
    assign key_start    = ks_reg;

endmodule

// ===== rtl/core/h265_rtp_fu_packetizer.sv =====
// H.265 RTP payload packetizer with fragmentation units.
// Input side: push/full. One NAL unit byte per beat, with the unit length,
// key-frame flag and a first-byte flag. Output side: empty/pop. One payload
// byte per beat with packet start/end, marker and key-start flags.
// cfg_write/cfg_data set max_payload at once; values are clamped to 16..1500.
// Units shorter than max_payload pass through as one payload. Others drop
// their two header bytes and are cut into fragments of max_payload - 3 data
// bytes, each led by a three-byte fragment header.
// Each byte passes through the command queue and then the output register.
// Throughput: one byte per cycle for pass-through and fragment data while
// pop is high; each fragment header adds three header bytes for the back part to send.
// A four-entry command queue absorbs these; once it fills, full holds the input
// until the back part takes the next command.
// When pop is held low the output register holds its beat and the queue
// fills, then full stalls the input. Reset empties the queue and output,
// clears the unit position and restores max_payload to 1400.
// Depends on hrfp_pkg, hrfp_front, hrfp_cmd_fifo and hrfp_back.
module h265_rtp_fu_packetizer #(
    parameter int MAX_UNIT_BYTES = hrfp_pkg::MAX_UNIT_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hrfp_pkg::MP_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [hrfp_pkg::BYTE_W-1:0]   nal_byte,
    input  logic [hrfp_pkg::LEN_IN_W-1:0] nal_length,
    input  logic                          key_unit,
    input  logic                          first_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [hrfp_pkg::BYTE_W-1:0]   out_byte,
    output logic                          packet_start,
    output logic                          packet_end,
    output logic                          marker,
    output logic                          key_start
);

    hrfp_pkg::cmd_t wr_cmd, head;
    logic           cmd_push, q_full, head_valid, head_pop;

    assign full = q_full;

    hrfp_front #(
        .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .push       (push),
        .nal_byte   (nal_byte),
        .nal_length (nal_length),
        .key_unit   (key_unit),
        .first_byte (first_byte),
        .q_full     (q_full),
        .cmd_push   (cmd_push),
        .cmd        (wr_cmd)
    );

    hrfp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (wr_cmd),
        .full     (q_full),
        .rd_en    (head_pop),
        .rd_data  (head),
        .rd_valid (head_valid)
    );

    hrfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .packet_start (packet_start),
        .packet_end   (packet_end),
        .marker       (marker),
        .key_start    (key_start)
    );

endmodule

// ===== rtl/core/hrfp_checker.sv =====
// Port-level checks for the packetizer, attached to the top level by bind.
// Depends on hrfp_pkg and h265_rtp_fu_packetizer.
module hrfp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [hrfp_pkg::BYTE_W-1:0] out_byte,
    input logic                        packet_start,
    input logic                        packet_end,
    input logic                        marker,
    input logic                        key_start
);

    // A waiting beat that is not taken stays in place unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(packet_start)
            && $stable(packet_end) && $stable(marker) && $stable(key_start)))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("output not empty after reset");

    a_reset_full: assert property (@(posedge clk)
        $rose(rst_n) |-> !full)
        else $error("input full after reset");

    // The final fragment's payload opens with the fragment type byte.
    a_marker_start: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && packet_start && marker)
            |-> (out_byte == hrfp_pkg::FU_TYPE_BYTE && !packet_end))
        else $error("marked payload does not open with a fragment header");

endmodule

bind h265_rtp_fu_packetizer hrfp_checker u_hrfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .packet_start (packet_start),
    .packet_end   (packet_end),
    .marker       (marker),
    .key_start    (key_start)
);

// ===== dv/h265_rtp_fu_packetizer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the H.265 RTP fragmentation-unit packetizer.
// Drives NAL unit bytes through push/full, predicts every payload beat and checks
// the pop/empty side against it. Depends on hrfp_pkg and h265_rtp_fu_packetizer.
module h265_rtp_fu_packetizer_tb;

    localparam int BYTE_W   = hrfp_pkg::BYTE_W;
    localparam int LEN_IN_W = hrfp_pkg::LEN_IN_W;
    localparam int MP_W     = hrfp_pkg::MP_W;
    localparam int TYPE_W   = hrfp_pkg::TYPE_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              ps;
        logic              pe;
        logic              mk;
        logic              ks;
    } payload_beat_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [MP_W-1:0]     cfg;
        logic [BYTE_W-1:0]   data;
        logic [LEN_IN_W-1:0] len;
        logic                key;
        logic                fb;
        logic                typed;
        logic [3:0]          want;  // {packet_start, packet_end, marker, key_start}
    } stim_row_t;

    localparam int NUM_ROWS = 25;
    localparam int RANDOM_ITEMS = 357;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [MP_W-1:0]     cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic [BYTE_W-1:0]   nal_byte = '0;
    logic [LEN_IN_W-1:0] nal_length = '0;
    logic                key_unit = 1'b0;
    logic                first_byte = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                packet_start;
    logic                packet_end;
    logic                marker;
    logic                key_start;

    // Predictor state, mirrors the block after reset.
    logic [MP_W-1:0]     max_payload_reg = hrfp_pkg::MP_RESET;
    int unsigned         unit_pos = 0;
    int unsigned         frag_left = 0;
    logic                in_fu = 1'b0;
    logic [TYPE_W-1:0]   fu_unit_type = '0;
    logic [BYTE_W-1:0]   nal_hdr2 = '0;
    logic                first_frag = 1'b1;

    payload_beat_t       payload_q[$];
    int unsigned         mismatches = 0;
    bit                  steady = 1'b0;

    stim_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{ROW_BEAT, 11'd0, 8'hFF, 21'd1, 1'b1, 1'b1, 1'b1, 4'b1101},
        '{ROW_BEAT, 11'd0, 8'h00, 21'd0, 1'b0, 1'b0, 1'b1, 4'b1100},
        '{ROW_BEAT, 11'd0, 8'h7E, 21'h1FFFFF, 1'b1, 1'b1, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'hA5, 21'h1FFFFF, 1'b1, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h11, 21'h1FFFFF, 1'b1, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h22, 21'h1FFFFF, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h33, 21'd3, 1'b0, 1'b1, 1'b1, 4'b1000},
        '{ROW_BEAT, 11'd0, 8'h44, 21'd3, 1'b0, 1'b0, 1'b1, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h55, 21'd3, 1'b0, 1'b0, 1'b1, 4'b0100},
        '{ROW_BEAT, 11'd0, 8'h66, 21'd5, 1'b1, 1'b0, 1'b1, 4'b1001},
        '{ROW_BEAT, 11'd0, 8'h77, 21'd5, 1'b1, 1'b0, 1'b1, 4'b0001},
        '{ROW_BEAT, 11'd0, 8'h88, 21'd2, 1'b0, 1'b0, 1'b1, 4'b1000},
        '{ROW_BEAT, 11'd0, 8'h99, 21'd2, 1'b0, 1'b0, 1'b1, 4'b0100},
        '{ROW_CFG,  11'd0, 8'h00, 21'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h40, 21'd16, 1'b1, 1'b1, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h01, 21'd16, 1'b1, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'hC3, 21'd16, 1'b1, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h3C, 21'd16, 1'b1, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h5A, 21'd5, 1'b1, 1'b0, 1'b0, 4'b0000},
        '{ROW_CFG,  11'h7FF, 8'h00, 21'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'hFF, 21'd1499, 1'b0, 1'b1, 1'b1, 4'b1000},
        '{ROW_BEAT, 11'd0, 8'h00, 21'd1500, 1'b1, 1'b1, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'hFF, 21'd1500, 1'b1, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h80, 21'd1500, 1'b1, 1'b0, 1'b0, 4'b0000},
        '{ROW_BEAT, 11'd0, 8'h01, 21'd1, 1'b0, 1'b1, 1'b1, 4'b1100}
    };

    h265_rtp_fu_packetizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .nal_byte     (nal_byte),
        .nal_length   (nal_length),
        .key_unit     (key_unit),
        .first_byte   (first_byte),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .packet_start (packet_start),
        .packet_end   (packet_end),
        .marker       (marker),
        .key_start    (key_start)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned clamp_payload(input logic [MP_W-1:0] setting);
        int unsigned mp;
        mp = int'(setting);
        if (mp < hrfp_pkg::MP_MIN)
            mp = hrfp_pkg::MP_MIN;
        if (mp > hrfp_pkg::MP_MAX)
            mp = hrfp_pkg::MP_MAX;
        return mp;
    endfunction

    function automatic void add_beat(input logic [BYTE_W-1:0] d, input logic ps,
                                     input logic pe, input logic mk, input logic ks);
        payload_q.insert(payload_q.size(), payload_beat_t'{d, ps, pe, mk, ks});
    endfunction

    // Works out the payload beats caused by one accepted NAL byte.
    function automatic void packetize_byte(input logic [BYTE_W-1:0] b,
                                           input logic [LEN_IN_W-1:0] len_in,
                                           input logic key, input logic fb);
        int unsigned mp;
        int unsigned chunk;
        int unsigned len;
        int unsigned pos;
        int unsigned rem;
        logic        last;
        logic        ks;
        logic        fin;
        logic        frag_end;
        logic [BYTE_W-1:0] flags;
        mp = clamp_payload(max_payload_reg);
        chunk = mp - hrfp_pkg::FU_HDR_BYTES;
        len = len_in;
        if (len < 1)
            len = 1;
        if (len > hrfp_pkg::MAX_UNIT_BYTES_DEF)
            len = hrfp_pkg::MAX_UNIT_BYTES_DEF;
        pos = fb ? 0 : unit_pos;
        if (pos >= len)
            pos = 0;
        if (pos == 0)
        begin
            in_fu = len > mp - 1;
            frag_left = 0;
            first_frag = 1'b1;
        end
        last = (pos + 1 >= len);
        if (!in_fu)
            add_beat(b, pos == 0, last, 1'b0, key);
        else if (pos == 0)
            fu_unit_type = b[6:1];
        else if (pos == 1)
            nal_hdr2 = b;
        else
        begin
            ks = first_frag && key;
            if (frag_left == 0)
            begin
                rem = len - pos;
                fin = rem <= chunk;
                frag_left = fin ? rem : chunk;
                flags = fin ? hrfp_pkg::FLAG_E : (first_frag ? hrfp_pkg::FLAG_S : '0);
                add_beat(hrfp_pkg::FU_TYPE_BYTE, 1'b1, 1'b0, fin, ks);
                add_beat(nal_hdr2, 1'b0, 1'b0, fin, ks);
                add_beat(flags | {2'b00, fu_unit_type}, 1'b0, 1'b0, fin, ks);
            end
            fin = (len - pos) <= frag_left;
            frag_left--;
            frag_end = (frag_left == 0) || last;
            add_beat(b, 1'b0, frag_end, fin, ks);
            if (frag_end)
            begin
                first_frag = 1'b0;
                frag_left = 0;
            end
        end
        unit_pos = last ? 0 : pos + 1;
    endfunction

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    // Sends one NAL byte, idling at random first. The beat is predicted once accepted;
    // a typed row replaces the predicted beat with the one written in the table.
    task automatic send_nal_byte(input logic [BYTE_W-1:0] data,
                                 input logic [LEN_IN_W-1:0] len, input logic key,
                                 input logic fb, input logic typed, input logic [3:0] want);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        nal_byte <= data;
        nal_length <= len;
        key_unit <= key;
        first_byte <= fb;
        @(posedge clk);
        while (full)
            @(posedge clk);
        packetize_byte(data, len, key, fb);
        if (typed)
        begin
            void'(payload_q.pop_back());
            add_beat(data, want[3], want[2], want[1], want[0]);
        end
    endtask

    // Lets the block drain fully, including header bytes that leave no result,
    // before touching max_payload.
    task automatic write_max_payload(input logic [MP_W-1:0] setting);
        push <= 1'b0;
        while (payload_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= setting;
        @(posedge clk);
        cfg_write <= 1'b0;
        max_payload_reg = setting;
    endtask

    task automatic run_phase(input logic [MP_W-1:0] setting, input int unsigned budget,
                             output int unsigned sent);
        int unsigned mp;
        int unsigned len;
        int unsigned count;
        int unsigned i;
        logic        key;
        logic        fb;
        write_max_payload(setting);
        mp = clamp_payload(setting);
        sent = 0;
        while (sent < budget)
        begin
            key = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 80)
            begin
                if (mp > 64)
                begin
                    // Long units at large payload sizes are started and then cut short.
                    if ($urandom_range(0, 3) == 0)
                    begin
                        len = $urandom_range(mp, 21'h1FFFFF);
                        count = $urandom_range(3, 12);
                    end
                    else
                    begin
                        len = $urandom_range(1, 12);
                        count = len;
                    end
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: len = $urandom_range(mp - 2, mp + 1);
                        1: len = $urandom_range(1, mp - 2);
                        default: len = $urandom_range(mp, 2 * mp + 4);
                    endcase
                    count = len;
                end
                // The phase's last unit is cut short so the phase sends exactly its budget.
                if (count > budget - sent)
                    count = budget - sent;
                for (i = 0; i < count; i++)
                begin
                    fb = (i == 0) && (unit_pos != 0 || $urandom_range(0, 3) != 0);
                    send_nal_byte(BYTE_W'($urandom_range(0, 255)), LEN_IN_W'(len), key, fb,
                                  1'b0, 4'b0000);
                end
            end
            else
            begin
                count = $urandom_range(1, 16);
                if (count > budget - sent)
                    count = budget - sent;
                len = $urandom_range(0, 1) ? $urandom_range(0, 21'h1FFFFF)
                                           : $urandom_range(0, 2 * mp);
                for (i = 0; i < count; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        len = $urandom_range(0, 40);
                    send_nal_byte(BYTE_W'($urandom_range(0, 255)), LEN_IN_W'(len),
                                  1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                                  1'b0, 4'b0000);
                end
            end
            sent += count;
        end
    endtask

    always @(posedge clk)
    begin
        pop <= steady || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge clk)
    begin : check_output
        payload_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (payload_q.size() == 0)
                report("unexpected beat", 0, out_byte);
            else
            begin
                want = payload_q.pop_front();
                if (out_byte !== want.data)
                    report("out_byte", want.data, out_byte);
                if (packet_start !== want.ps)
                    report("packet_start", want.ps, packet_start);
                if (packet_end !== want.pe)
                    report("packet_end", want.pe, packet_end);
                if (marker !== want.mk)
                    report("marker", want.mk, marker);
                if (key_start !== want.ks)
                    report("key_start", want.ks, key_start);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned     r;
        int unsigned     phase;
        int unsigned     sent;
        int unsigned     random_items;
        logic [MP_W-1:0] setting;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < NUM_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_max_payload(directed_rows[r].cfg);
            else
                send_nal_byte(directed_rows[r].data, directed_rows[r].len,
                              directed_rows[r].key, directed_rows[r].fb,
                              directed_rows[r].typed, directed_rows[r].want);
        end

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase % 8)
                0: setting = hrfp_pkg::MP_MIN;
                1: setting = MP_W'($urandom_range(17, 40));
                2: setting = '0;
                3: setting = '1;
                4: setting = MP_W'($urandom_range(16, 48));
                5: setting = hrfp_pkg::MP_MAX;
                6: setting = MP_W'($urandom_range(16, 32));
                default: setting = hrfp_pkg::MP_RESET;
            endcase
            // One phase runs with neither side idling.
            steady = (phase == 2);
            run_phase(setting, clamp_payload(setting) > 64 ? 30 : 60, sent);
            random_items += sent;
            phase++;
        end

        steady = 1'b0;
        push <= 1'b0;
        while (payload_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
